>>> src/assert_macros.svh
// Assertion macros used by the controller top level.
// Depends on nothing; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> src/jctc_pkg.sv
// Package for the joint cascade torque controller: payload types,
// mode and register codes, sequencer and ALU enums. No dependencies.
package jctc_pkg;

  localparam int unsigned QW = 32;   // Q16.16 word
  localparam int unsigned GW = 31;   // unsigned gain registers
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    MODE_CURRENT  = 3'd0,
    MODE_TORQUE   = 3'd1,
    MODE_PD       = 3'd2,
    MODE_VELOCITY = 3'd3,
    MODE_POSITION = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTROL_MODE      = 3'd0,
    CFG_POS_LIMIT_LOW     = 3'd1,
    CFG_POS_LIMIT_HIGH    = 3'd2,
    CFG_STOP_STIFFNESS    = 3'd3,
    CFG_STOP_DAMPING      = 3'd4,
    CFG_TORQUE_CLAMP      = 3'd5,
    CFG_INTEGRAL_GAIN     = 3'd6,
    CFG_CURRENT_PER_TORQ  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REGION_INSIDE = 2'd0,
    REGION_LOWER  = 2'd1,
    REGION_UPPER  = 2'd2
  } region_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PERR,
    S_KP_MUL,
    S_KP_RND,
    S_CVEL,
    S_VERR,
    S_KD_MUL,
    S_KD_RND,
    S_PI_SUM,
    S_FF,
    S_STOP_ERR,
    S_SK_MUL,
    S_SK_RND,
    S_NVEL,
    S_SD_MUL,
    S_SD_RND,
    S_STOP_SUM,
    S_CLAMP,
    S_IQ_MUL,
    S_IQ_RND,
    S_KI_MUL,
    S_KI_RND,
    S_INTEG,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_RND,
    ALU_CLAMP
  } alu_op_e;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_PE,
    DST_CV,
    DST_VE,
    DST_TQ,
    DST_T1,
    DST_T2,
    DST_IQ,
    DST_INTEG
  } dst_e;

  typedef struct packed {
    logic signed [QW-1:0] target_position;
    logic signed [QW-1:0] target_velocity;
    logic signed [QW-1:0] stiffness_gain;
    logic signed [QW-1:0] damping_gain;
    logic signed [QW-1:0] feedforward_torque;
    logic signed [QW-1:0] measured_position;
    logic signed [QW-1:0] measured_velocity;
    logic                 restart;
  } in_payload_t;

  typedef struct packed {
    logic signed [QW-1:0] torque_command;
    logic signed [QW-1:0] current_q_ref;
    logic                 current_ref_valid;
    logic [1:0]           stop_region;
    logic signed [QW-1:0] integrator_value;
  } out_payload_t;

  // Sequencer control word for the shared unit
  typedef struct packed {
    alu_op_e              op;
    logic signed [QW-1:0] a;
    logic signed [QW-1:0] b;
    dst_e                 dst;
  } alu_ctrl_t;

endpackage

>>> src/jctc_ifs.sv
// Valid/ready stream interfaces for the controller's setpoint and result.
// Depends on jctc_pkg for the payload types.
interface jctc_in_if;
  logic                  valid;
  logic                  ready;
  jctc_pkg::in_payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jctc_out_if;
  logic                   valid;
  logic                   ready;
  jctc_pkg::out_payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/joint_cascade_torque_controller.sv
// Cascaded position/velocity PI joint torque controller, top level; needs jctc_pkg,
// jctc_ifs.sv and assert_macros.svh.
// Each request runs a sequence of steps on the shared unit; the steps depend on the mode,
// and an active soft stop adds the stop stiffness and damping steps.
// A new request is taken only while idle, after the last result has been loaded; all math goes through one shared unit.
// Reset: async active low; config to defaults, integrator to zero, idle.
`include "assert_macros.svh"

module joint_cascade_torque_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [jctc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [jctc_pkg::QW-1:0]            cfg_data_i,
  jctc_in_if.sink                            in_i,
  jctc_out_if.source                         out_o
);

  localparam int unsigned QW = jctc_pkg::QW;
  localparam int unsigned GW = jctc_pkg::GW;
  localparam int unsigned PW = 2 * QW;
  localparam int unsigned SW = PW - 16;

  localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

  // configuration
  logic [2:0]           mode_q;
  logic signed [QW-1:0] lim_low_q, lim_high_q;
  logic [GW-1:0]        stop_k_q, stop_d_q, clamp_q, ki_q, cpt_q;

  // datapath
  jctc_pkg::state_e     state_q, state_d;
  jctc_pkg::in_payload_t req_q;
  logic signed [QW-1:0] pe_q, cv_q, ve_q, tq_q, t1_q, t2_q, iq_q, integ_q;
  logic signed [PW-1:0] prod_q;
  logic [1:0]           region_q;

  logic                   out_valid_q;
  jctc_pkg::out_payload_t out_data_q;

  jctc_pkg::alu_ctrl_t  ctl;
  logic signed [QW-1:0] alu_res;
  logic signed [PW-1:0] alu_prod;

  logic is_pos, is_vel, is_pd, is_trq, is_pi, is_ctl;
  logic in_fire, out_load;

  assign is_pos = (mode_q == jctc_pkg::MODE_POSITION);
  assign is_vel = (mode_q == jctc_pkg::MODE_VELOCITY);
  assign is_pd  = (mode_q == jctc_pkg::MODE_PD);
  assign is_trq = (mode_q == jctc_pkg::MODE_TORQUE);
  assign is_pi  = is_pos | is_vel;
  assign is_ctl = is_pi | is_pd | is_trq;

  assign in_i.ready = (state_q == jctc_pkg::S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_load   = (state_q == jctc_pkg::S_DONE) & (~out_valid_q | out_o.ready);

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // ---------------- shared arithmetic unit ----------------
  logic signed [QW:0]   sum;
  logic signed [PW-1:0] rnd_t;
  logic signed [SW-1:0] rnd_s;
  logic signed [QW-1:0] clamp_pos, clamp_neg;

  always_comb begin
    sum       = '0;
    rnd_t     = '0;
    rnd_s     = '0;
    clamp_pos = $signed({1'b0, clamp_q});
    clamp_neg = -clamp_pos;
    alu_res   = '0;
    alu_prod  = ctl.a * ctl.b;
    case (ctl.op)
      jctc_pkg::ALU_ADD, jctc_pkg::ALU_SUB: begin
        if (ctl.op == jctc_pkg::ALU_ADD) begin
          sum = {ctl.a[QW-1], ctl.a} + {ctl.b[QW-1], ctl.b};
        end else begin
          sum = {ctl.a[QW-1], ctl.a} - {ctl.b[QW-1], ctl.b};
        end
        if (sum[QW] != sum[QW-1]) begin
          alu_res = sum[QW] ? QMIN : QMAX;
        end else begin
          alu_res = sum[QW-1:0];
        end
      end
      jctc_pkg::ALU_RND: begin
        // round half up, then floor by arithmetic shift
        rnd_t = prod_q + PW'(32768);
        rnd_s = rnd_t[PW-1:16];
        if (rnd_s > SW'(QMAX)) begin
          alu_res = QMAX;
        end else if (rnd_s < SW'(QMIN)) begin
          alu_res = QMIN;
        end else begin
          alu_res = rnd_s[QW-1:0];
        end
      end
      jctc_pkg::ALU_CLAMP: begin
        if (ctl.a > clamp_pos) begin
          alu_res = clamp_pos;
        end else if (ctl.a < clamp_neg) begin
          alu_res = clamp_neg;
        end else begin
          alu_res = ctl.a;
        end
      end
      default: alu_res = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    ctl.op  = jctc_pkg::ALU_NOP;
    ctl.a   = '0;
    ctl.b   = '0;
    ctl.dst = jctc_pkg::DST_NONE;
    case (state_q)
      jctc_pkg::S_IDLE: begin
        if (in_fire) state_d = jctc_pkg::S_PERR;
      end
      jctc_pkg::S_PERR: begin
        ctl = '{jctc_pkg::ALU_SUB, req_q.target_position, req_q.measured_position,
                jctc_pkg::DST_PE};
        if (is_pos || is_pd) state_d = jctc_pkg::S_KP_MUL;
        else if (is_vel)     state_d = jctc_pkg::S_VERR;
        else if (is_trq)     state_d = jctc_pkg::S_FF;
        else                 state_d = jctc_pkg::S_DONE;
      end
      jctc_pkg::S_KP_MUL: begin
        ctl = '{jctc_pkg::ALU_MUL, req_q.stiffness_gain, pe_q, jctc_pkg::DST_NONE};
        state_d = jctc_pkg::S_KP_RND;
      end
      jctc_pkg::S_KP_RND: begin
        ctl.op  = jctc_pkg::ALU_RND;
        ctl.dst = jctc_pkg::DST_T1;
        state_d = is_pos ? jctc_pkg::S_CVEL : jctc_pkg::S_VERR;
      end
      jctc_pkg::S_CVEL: begin
        ctl = '{jctc_pkg::ALU_ADD, cv_q, t1_q, jctc_pkg::DST_CV};
        state_d = jctc_pkg::S_VERR;
      end
      jctc_pkg::S_VERR: begin
        ctl = '{jctc_pkg::ALU_SUB, cv_q, req_q.measured_velocity, jctc_pkg::DST_VE};
        state_d = jctc_pkg::S_KD_MUL;
      end
      jctc_pkg::S_KD_MUL: begin
        ctl = '{jctc_pkg::ALU_MUL, req_q.damping_gain, ve_q, jctc_pkg::DST_NONE};
        state_d = jctc_pkg::S_KD_RND;
      end
      jctc_pkg::S_KD_RND: begin
        ctl.op  = jctc_pkg::ALU_RND;
        ctl.dst = jctc_pkg::DST_T2;
        state_d = jctc_pkg::S_PI_SUM;
      end
      jctc_pkg::S_PI_SUM: begin
        // PI loops add the integrator; pd adds the stiffness term held in t1
        ctl = '{jctc_pkg::ALU_ADD, t2_q, (is_pi ? integ_q : t1_q), jctc_pkg::DST_TQ};
        state_d = jctc_pkg::S_FF;
      end
      jctc_pkg::S_FF: begin
        ctl = '{jctc_pkg::ALU_ADD, tq_q, req_q.feedforward_torque, jctc_pkg::DST_TQ};
        state_d = (region_q != jctc_pkg::REGION_INSIDE) ? jctc_pkg::S_STOP_ERR
                                                         : jctc_pkg::S_CLAMP;
      end
      jctc_pkg::S_STOP_ERR: begin
        ctl = '{jctc_pkg::ALU_SUB,
                ((region_q == jctc_pkg::REGION_LOWER) ? lim_low_q : lim_high_q),
                req_q.measured_position, jctc_pkg::DST_T1};
        state_d = jctc_pkg::S_SK_MUL;
      end
      jctc_pkg::S_SK_MUL: begin
        ctl = '{jctc_pkg::ALU_MUL, $signed({1'b0, stop_k_q}), t1_q, jctc_pkg::DST_NONE};
        state_d = jctc_pkg::S_SK_RND;
      end
      jctc_pkg::S_SK_RND: begin
        ctl.op  = jctc_pkg::ALU_RND;
        ctl.dst = jctc_pkg::DST_T2;
        state_d = jctc_pkg::S_NVEL;
      end
      jctc_pkg::S_NVEL: begin
        ctl = '{jctc_pkg::ALU_SUB, '0, req_q.measured_velocity, jctc_pkg::DST_T1};
        state_d = jctc_pkg::S_SD_MUL;
      end
      jctc_pkg::S_SD_MUL: begin
        ctl = '{jctc_pkg::ALU_MUL, $signed({1'b0, stop_d_q}), t1_q, jctc_pkg::DST_NONE};
        state_d = jctc_pkg::S_SD_RND;
      end
      jctc_pkg::S_SD_RND: begin
        ctl.op  = jctc_pkg::ALU_RND;
        ctl.dst = jctc_pkg::DST_T1;
        state_d = jctc_pkg::S_STOP_SUM;
      end
      jctc_pkg::S_STOP_SUM: begin
        ctl = '{jctc_pkg::ALU_ADD, t2_q, t1_q, jctc_pkg::DST_TQ};
        state_d = jctc_pkg::S_CLAMP;
      end
      jctc_pkg::S_CLAMP: begin
        ctl = '{jctc_pkg::ALU_CLAMP, tq_q, '0, jctc_pkg::DST_TQ};
        state_d = jctc_pkg::S_IQ_MUL;
      end
      jctc_pkg::S_IQ_MUL: begin
        ctl = '{jctc_pkg::ALU_MUL, tq_q, $signed({1'b0, cpt_q}), jctc_pkg::DST_NONE};
        state_d = jctc_pkg::S_IQ_RND;
      end
      jctc_pkg::S_IQ_RND: begin
        ctl.op  = jctc_pkg::ALU_RND;
        ctl.dst = jctc_pkg::DST_IQ;
        state_d = is_pi ? jctc_pkg::S_KI_MUL : jctc_pkg::S_DONE;
      end
      jctc_pkg::S_KI_MUL: begin
        ctl = '{jctc_pkg::ALU_MUL, $signed({1'b0, ki_q}), ve_q, jctc_pkg::DST_NONE};
        state_d = jctc_pkg::S_KI_RND;
      end
      jctc_pkg::S_KI_RND: begin
        ctl.op  = jctc_pkg::ALU_RND;
        ctl.dst = jctc_pkg::DST_T1;
        state_d = jctc_pkg::S_INTEG;
      end
      jctc_pkg::S_INTEG: begin
        ctl = '{jctc_pkg::ALU_ADD, integ_q, t1_q, jctc_pkg::DST_INTEG};
        state_d = jctc_pkg::S_DONE;
      end
      jctc_pkg::S_DONE: begin
        if (out_load) state_d = jctc_pkg::S_IDLE;
      end
      default: state_d = jctc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jctc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= jctc_pkg::MODE_CURRENT;
      lim_low_q  <= QMIN;
      lim_high_q <= QMAX;
      stop_k_q   <= '0;
      stop_d_q   <= '0;
      clamp_q    <= '0;
      ki_q       <= '0;
      cpt_q      <= GW'(65536);
    end else if (cfg_we_i) begin
      case (jctc_pkg::cfg_idx_e'(cfg_idx_i))
        jctc_pkg::CFG_CONTROL_MODE:     mode_q     <= cfg_data_i[2:0];
        jctc_pkg::CFG_POS_LIMIT_LOW:    lim_low_q  <= $signed(cfg_data_i);
        jctc_pkg::CFG_POS_LIMIT_HIGH:   lim_high_q <= $signed(cfg_data_i);
        jctc_pkg::CFG_STOP_STIFFNESS:   stop_k_q   <= cfg_data_i[GW-1:0];
        jctc_pkg::CFG_STOP_DAMPING:     stop_d_q   <= cfg_data_i[GW-1:0];
        jctc_pkg::CFG_TORQUE_CLAMP:     clamp_q    <= cfg_data_i[GW-1:0];
        jctc_pkg::CFG_INTEGRAL_GAIN:    ki_q       <= cfg_data_i[GW-1:0];
        jctc_pkg::CFG_CURRENT_PER_TORQ: cpt_q      <= cfg_data_i[GW-1:0];
        default: ;
      endcase
    end
  end

  // integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (in_fire && in_i.data.restart) begin
      integ_q <= '0;
    end else if (ctl.dst == jctc_pkg::DST_INTEG) begin
      integ_q <= alu_res;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_i.data;
      cv_q  <= in_i.data.target_velocity;
      tq_q  <= '0;
    end
    if (state_q == jctc_pkg::S_PERR) begin
      // lower stop is checked first and wins
      if (req_q.measured_position <= lim_low_q) begin
        region_q <= jctc_pkg::REGION_LOWER;
      end else if (req_q.measured_position >= lim_high_q) begin
        region_q <= jctc_pkg::REGION_UPPER;
      end else begin
        region_q <= jctc_pkg::REGION_INSIDE;
      end
    end
    if (ctl.op == jctc_pkg::ALU_MUL) prod_q <= alu_prod;
    case (ctl.dst)
      jctc_pkg::DST_PE: pe_q <= alu_res;
      jctc_pkg::DST_CV: cv_q <= alu_res;
      jctc_pkg::DST_VE: ve_q <= alu_res;
      jctc_pkg::DST_TQ: tq_q <= alu_res;
      jctc_pkg::DST_T1: t1_q <= alu_res;
      jctc_pkg::DST_T2: t2_q <= alu_res;
      jctc_pkg::DST_IQ: iq_q <= alu_res;
      default: ;
    endcase
    if (out_load) begin
      out_data_q.torque_command    <= is_ctl ? tq_q : '0;
      out_data_q.current_q_ref     <= is_ctl ? iq_q : '0;
      out_data_q.current_ref_valid <= is_ctl;
      out_data_q.stop_region       <= is_ctl ? region_q : jctc_pkg::REGION_INSIDE;
      out_data_q.integrator_value  <= integ_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // ---------------- assertions ----------------
  `ASSERT_CLK(a_accept_starts_seq, clk_i, rst_ni,
    in_fire |=> (state_q == jctc_pkg::S_PERR))
  `ASSERT_NEVER(a_region_code, clk_i, rst_ni,
    out_valid_q && (out_data_q.stop_region == 2'd3))
  `ASSERT_CLK(a_no_ref_zero, clk_i, rst_ni,
    (out_valid_q && !out_data_q.current_ref_valid) |->
      (out_data_q.torque_command == '0 && out_data_q.current_q_ref == '0))
  `ASSERT_CLK(a_torque_clamped, clk_i, rst_ni,
    (out_valid_q && out_data_q.current_ref_valid) |->
      (out_data_q.torque_command <= $signed({1'b0, clamp_q}) &&
       out_data_q.torque_command >= -$signed({1'b0, clamp_q})))
  `ASSERT_NEVER(a_load_while_busy_out, clk_i, rst_ni,
    out_load && out_valid_q && !out_o.ready)

endmodule
